FILE: hw/rtl/udwm_pkg.sv
// ----------------------------------------------------------------------------
// udwm_pkg
// Types and constants shared by the UTF-8 display width meter.
// ----------------------------------------------------------------------------
package udwm_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned COLS_W   = 16;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned N_WIDE   = 16;

  localparam logic [COLS_W-1:0] BUDGET_RESET = 16'd80;
  localparam logic [7:0]        CONT_MASK    = 8'h3F;

  // Register word index carried in paddr[2]
  localparam logic REG_WIDTH_BUDGET = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } udwm_in_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [1:0]        cell_width;
    logic [COLS_W-1:0] running_columns;
    logic              within_budget;
    logic              string_end;
  } udwm_out_t;

  // What the decoder hands on for one byte
  typedef struct packed {
    logic            emit;
    logic            string_end;
    logic [CP_W-1:0] code_point;
  } udwm_dec_t;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } udwm_range_t;

  // East Asian wide and emoji blocks
  localparam udwm_range_t WIDE_BLOCKS [N_WIDE] = '{
    '{21'h01100, 21'h0115F}, '{21'h02E80, 21'h0303E}, '{21'h03041, 21'h033FF},
    '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF}, '{21'h0A000, 21'h0A4CF},
    '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF}, '{21'h0FE30, 21'h0FE4F},
    '{21'h0FF00, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6}, '{21'h1F300, 21'h1F64F},
    '{21'h1F680, 21'h1F6FF}, '{21'h1F900, 21'h1F9FF}, '{21'h1FA70, 21'h1FAFF},
    '{21'h20000, 21'h3FFFD}
  };

endpackage

FILE: hw/rtl/utf8_display_width_meter.sv
// ----------------------------------------------------------------------------
// utf8_display_width_meter
// UTF-8 decoder with terminal column metering and a column budget flag.
// ----------------------------------------------------------------------------
// A completing byte passes through the byte register and then the result register.
// Throughput: one byte per cycle while cp_ready is not held low; a byte register
// feeds decode, width lookup and the column add, which land in the result register.
// Reset (rst, synchronous) empties both registers, drops any open sequence,
// clears the column total and budget flag, and sets width_budget to 80.
module utf8_display_width_meter
  import udwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  udwm_in_t            byte_item,
  output logic                cp_valid,
  input  logic                cp_ready,
  output udwm_out_t           cp_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic              s1_valid;
  udwm_in_t          s1_item;
  logic              step;
  udwm_dec_t         dec;
  logic [1:0]        cell_width;
  logic [COLS_W-1:0] running_columns;
  logic              within_budget;
  logic [COLS_W-1:0] width_budget;

  // ---- configuration ----
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_budget <= BUDGET_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WIDTH_BUDGET)) begin
      width_budget <= pwdata[COLS_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_WIDTH_BUDGET) begin
      prdata = {{(PDATA_W-COLS_W){1'b0}}, width_budget};
    end else begin
      prdata = '0;
    end
  end

  // ---- byte register ----
  assign step       = s1_valid && (!cp_valid || cp_ready);
  assign byte_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_item <= byte_item;
    end
  end

  udwm_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s1_item),
    .dec  (dec)
  );

  udwm_width_class u_width (
    .code_point (dec.code_point),
    .cell_width (cell_width)
  );

  udwm_meter u_meter (
    .clk             (clk),
    .rst             (rst),
    .commit          (step && dec.emit),
    .string_end      (dec.string_end),
    .cell_width      (cell_width),
    .width_budget    (width_budget),
    .running_columns (running_columns),
    .within_budget   (within_budget)
  );

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (step) begin
      cp_valid <= dec.emit;
    end else if (cp_ready) begin
      cp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && dec.emit) begin
      cp_item.code_point      <= dec.code_point;
      cp_item.cell_width      <= cell_width;
      cp_item.running_columns <= running_columns;
      cp_item.within_budget   <= within_budget;
      cp_item.string_end      <= dec.string_end;
    end
  end

`ifndef SYNTH
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cp_valid && !cp_ready |-> !step)
    else $error("pending result overwritten");

  a_width_code: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> cp_item.cell_width != 2'd3)
    else $error("illegal cell width");

  // a byte waiting in the byte register with room downstream moves on
  a_drain: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !cp_valid |=> !s1_valid || $past(byte_valid && byte_ready))
    else $error("byte register stalled");
`endif

endmodule

FILE: hw/rtl/udwm_decode.sv
// ----------------------------------------------------------------------------
// udwm_decode
// UTF-8 sequence assembly: lead byte length, continuation gathering and
// codepoint build, including sequences cut short by the end of the string.
// ----------------------------------------------------------------------------
module udwm_decode
  import udwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  udwm_in_t  item,
  output udwm_dec_t dec
);

  logic [7:0]  held_lead;
  logic [17:0] partial_value;
  logic [2:0]  bytes_expected;
  logic [2:0]  bytes_seen;

  logic [7:0]  held_lead_next;
  logic [17:0] partial_value_next;
  logic [2:0]  bytes_expected_next;
  logic [2:0]  bytes_seen_next;

  logic [7:0]  lead;
  logic [17:0] part;
  logic [2:0]  seen;
  logic [2:0]  expect_len;
  logic [2:0]  lead_len;
  logic [7:0]  cont;

  always_comb begin
    if (item.data_byte[7] == 1'b0) begin
      lead_len = 3'd1;
    end else if (item.data_byte[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (item.data_byte[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (item.data_byte[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd1;
    end
  end

  assign cont = item.data_byte & CONT_MASK;

  always_comb begin
    if (bytes_expected == 3'd0) begin
      lead       = item.data_byte;
      part       = '0;
      seen       = 3'd1;
      expect_len = lead_len;
    end else begin
      lead       = held_lead;
      part       = {partial_value[11:0], cont[5:0]};
      seen       = bytes_seen + 3'd1;
      expect_len = bytes_expected;
    end
  end

  always_comb begin
    dec.emit       = (seen >= expect_len) || item.is_last;
    dec.string_end = item.is_last;
    case (seen)
      3'd2:    dec.code_point = {10'd0, lead[4:0], part[5:0]};
      3'd3:    dec.code_point = {5'd0, lead[3:0], part[11:0]};
      3'd4:    dec.code_point = {lead[2:0], part[17:0]};
      default: dec.code_point = {13'd0, lead};
    endcase
  end

  always_comb begin
    held_lead_next      = held_lead;
    partial_value_next  = partial_value;
    bytes_expected_next = bytes_expected;
    bytes_seen_next     = bytes_seen;
    if (step) begin
      if (dec.emit) begin
        held_lead_next      = '0;
        partial_value_next  = '0;
        bytes_expected_next = '0;
        bytes_seen_next     = '0;
      end else begin
        held_lead_next      = lead;
        partial_value_next  = part;
        bytes_expected_next = expect_len;
        bytes_seen_next     = seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead      <= '0;
      partial_value  <= '0;
      bytes_expected <= '0;
      bytes_seen     <= '0;
    end else begin
      held_lead      <= held_lead_next;
      partial_value  <= partial_value_next;
      bytes_expected <= bytes_expected_next;
      bytes_seen     <= bytes_seen_next;
    end
  end

`ifndef SYNTH
  // An open sequence always still lacks at least one byte
  a_open_seq: assert property (@(posedge clk) disable iff (rst)
    bytes_expected != 3'd0 |-> bytes_seen != 3'd0 && bytes_seen < bytes_expected)
    else $error("open sequence byte count out of range");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    bytes_expected == 3'd0 |-> bytes_seen == 3'd0 && partial_value == '0)
    else $error("sequence state not cleared");
`endif

endmodule

FILE: hw/rtl/udwm_width_class.sv
// ----------------------------------------------------------------------------
// udwm_width_class
// Display column count of one codepoint: zero-width, normal or wide.
// ----------------------------------------------------------------------------
module udwm_width_class
  import udwm_pkg::*;
(
  input  logic [CP_W-1:0] code_point,
  output logic [1:0]      cell_width
);

  logic [N_WIDE-1:0] hit;
  logic              zero_w;

  always_comb begin
    for (int k = 0; k < N_WIDE; k++) begin
      hit[k] = (code_point >= WIDE_BLOCKS[k].lo) && (code_point <= WIDE_BLOCKS[k].hi);
    end
  end

  // controls, combining diacritics, zero-width spaces and BOM
  assign zero_w = (code_point < 21'h00020)
               || ((code_point >= 21'h0007F) && (code_point < 21'h000A0))
               || ((code_point >= 21'h00300) && (code_point <= 21'h0036F))
               || ((code_point >= 21'h0200B) && (code_point <= 21'h0200F))
               || (code_point == 21'h0FEFF);

  always_comb begin
    if (zero_w) begin
      cell_width = 2'd0;
    end else if (|hit) begin
      cell_width = 2'd2;
    end else begin
      cell_width = 2'd1;
    end
  end

endmodule

FILE: hw/rtl/udwm_meter.sv
// ----------------------------------------------------------------------------
// udwm_meter
// Saturating column total per string and the sticky budget test.
// ----------------------------------------------------------------------------
module udwm_meter
  import udwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  logic              string_end,
  input  logic [1:0]        cell_width,
  input  logic [COLS_W-1:0] width_budget,
  output logic [COLS_W-1:0] running_columns,
  output logic              within_budget
);

  logic [COLS_W-1:0] column_total;
  logic              budget_broken;
  logic [COLS_W-1:0] column_total_next;
  logic              budget_broken_next;
  logic [COLS_W:0]   sum;

  assign sum             = {1'b0, column_total} + {{(COLS_W-1){1'b0}}, cell_width};
  assign within_budget   = !budget_broken && (sum <= {1'b0, width_budget});
  assign running_columns = sum[COLS_W] ? {COLS_W{1'b1}} : sum[COLS_W-1:0];

  always_comb begin
    column_total_next  = column_total;
    budget_broken_next = budget_broken;
    if (commit) begin
      if (string_end) begin
        column_total_next  = '0;
        budget_broken_next = 1'b0;
      end else begin
        column_total_next  = running_columns;
        budget_broken_next = budget_broken || !within_budget;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_total  <= '0;
      budget_broken <= 1'b0;
    end else begin
      column_total  <= column_total_next;
      budget_broken <= budget_broken_next;
    end
  end

`ifndef SYNTH
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> column_total == '0 && !budget_broken)
    else $error("meter state not cleared by reset");
`endif

endmodule
